// ===== rtl/casefold_crc32_msb_hash_defines.svh =====
// Assertion macros shared by the casefold CRC32 hash RTL.
// Define ASSERT_OFF to compile the checks away; no other dependencies.
`ifndef CASEFOLD_CRC32_MSB_HASH_DEFINES_SVH
`define CASEFOLD_CRC32_MSB_HASH_DEFINES_SVH

`ifndef ASSERT_OFF
`define CFCH_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("cfch assertion failed");
`define CFCH_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("cfch assertion failed");
`else
`define CFCH_ASSERT(label, clk, rst, prop)
`define CFCH_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ===== rtl/cfch_pkg.sv =====
// Package for the casefold CRC32 hash: queue item type, character constants
// and the MSB-first CRC table function. No dependencies.
package cfch_pkg;

   localparam logic [31:0] HASH_POLY    = 32'h04c1_1db7;
   localparam logic [7:0]  CHAR_UPPER_A = 8'h41;
   localparam logic [7:0]  CHAR_UPPER_Z = 8'h5a;
   localparam logic [7:0]  CASE_BIT     = 8'h20;
   localparam logic [2:0]  FILL_FULL    = 3'd4;

   typedef struct packed {
      logic       last;       // terminating zero byte
      logic [7:0] data_byte;  // folded byte
   } item_type;

   // Entry idx of the MSB-first CRC table; reduces to a fixed XOR network.
   function automatic logic [31:0] crc_table_entry(input logic [7:0] idx);
      logic [31:0] v;
      v = {idx, 24'h00_0000};
      for (int k = 0; k < 8; k++) begin
         v = v[31] ? ({v[30:0], 1'b0} ^ HASH_POLY) : {v[30:0], 1'b0};
      end
      return v;
   endfunction

endpackage

// ===== rtl/cfch_front.sv =====
// Front end of the casefold CRC32 hash: accepts bytes, tracks double-byte
// lead/trail state and folds ASCII capitals. Depends on cfch_pkg.
module cfch_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,   // [7:0] data_byte
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic                csr_data,    // fold_case
   input  logic                queue_full,
   output logic                push,
   output cfch_pkg::item_type  push_item
);

   logic fold_ff, fold_in;
   logic skip_ff, skip_in;
   logic [7:0] byte_out;

   assign csr_ready  = 1'b1;
   assign req_tready = !queue_full;
   assign push       = req_tvalid && req_tready;

   always_comb begin
      fold_in = fold_ff;
      if (csr_valid && csr_ready) begin
         fold_in = csr_data;
      end
   end

   always_comb begin
      skip_in  = skip_ff;
      byte_out = req_tdata;
      if (push) begin
         if (req_tdata == 8'h00) begin
            skip_in = 1'b0;
         end else if (skip_ff) begin
            skip_in = 1'b0;
         end else if (req_tdata[7]) begin
            skip_in = 1'b1;
         end else if (fold_ff && req_tdata >= cfch_pkg::CHAR_UPPER_A
                      && req_tdata <= cfch_pkg::CHAR_UPPER_Z) begin
            byte_out = req_tdata | cfch_pkg::CASE_BIT;
         end
      end
   end

   assign push_item.last      = (req_tdata == 8'h00);
   assign push_item.data_byte = byte_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_ff <= 1'b1;
         skip_ff <= 1'b0;
      end else begin
         fold_ff <= fold_in;
         skip_ff <= skip_in;
      end
   end

endmodule

// ===== rtl/cfch_queue.sv =====
// Short queue between the front end and the hash unit of the casefold
// CRC32 hash. Depends on cfch_pkg and the shared assertion macros.
`include "casefold_crc32_msb_hash_defines.svh"

module cfch_queue #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  cfch_pkg::item_type  push_item,
   input  logic                pop,
   output logic                not_empty,
   output logic                full,
   output cfch_pkg::item_type  head_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cfch_pkg::item_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign head_item = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   `CFCH_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH))
   `CFCH_ASSERT(a_no_pop_empty, clock, reset, pop |-> not_empty)
   `CFCH_ASSERT(a_no_push_full, clock, reset, push |-> !full)
   `CFCH_ASSERT(a_push_fills, clock, reset, (push && !pop) |=> not_empty)

endmodule

// ===== rtl/cfch_back.sv =====
// Hash unit of the casefold CRC32 hash: packs the first four bytes, runs
// the MSB-first CRC update and holds the result register. Depends on cfch_pkg.
module cfch_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_valid,
   input  cfch_pkg::item_type  item,
   output logic                pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [31:0]         rsp_tdata    // [31:0] hash_value
);

   logic [31:0] crc_ff, crc_in;
   logic [2:0]  fill_ff, fill_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff, rsp_data_in;
   logic [31:0] shifted;
   logic [31:0] hash;

   // A terminator needs a free output slot; other bytes never wait.
   assign pop = item_valid && (!item.last || !rsp_valid_ff || rsp_tready);

   assign shifted = {crc_ff[23:0], item.data_byte};

   always_comb begin
      case (fill_ff)
         3'd0:    hash = 32'h0000_0000;
         3'd1:    hash = {crc_ff[7:0], 24'h00_0000};
         3'd2:    hash = {crc_ff[15:0], 16'h0000};
         3'd3:    hash = {crc_ff[23:0], 8'h00};
         default: hash = ~crc_ff;
      endcase
   end

   always_comb begin
      crc_in  = crc_ff;
      fill_in = fill_ff;
      if (pop) begin
         if (item.last) begin
            crc_in  = '0;
            fill_in = '0;
         end else if (fill_ff < cfch_pkg::FILL_FULL) begin
            fill_in = fill_ff + 1'b1;
            // The register is inverted once the fourth byte is packed.
            crc_in  = (fill_ff == cfch_pkg::FILL_FULL - 3'd1) ? ~shifted : shifted;
         end else begin
            crc_in = cfch_pkg::crc_table_entry(crc_ff[31:24]) ^ shifted;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (pop && item.last) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = hash;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         crc_ff       <= crc_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== rtl/casefold_crc32_msb_hash.sv =====
// Casefold CRC32 path hash, top level.
// Depends on cfch_pkg, cfch_front, cfch_queue and cfch_back.
//
// Usage: path bytes enter on the req_ stream, one per transaction. A zero
// byte ends the string; one transaction then leaves on the rsp_ stream
// carrying the 32-bit hash. Nonzero bytes produce no output.
// The csr_ channel writes fold_case (bit 0); csr_ready is always high, and
// a write takes effect from the next accepted byte.
// Throughput: one byte per cycle while the queue is not full. The front end
// classifies and folds the byte, a queue of QUEUE_DEPTH entries holds it,
// and the hash unit packs the first four bytes, then applies one table
// lookup, shift and XOR per byte. rsp_tvalid comes from a registered output.
// If the receiver stalls with a hash held in the output register, the next
// terminator waits in the queue; req_tready drops only when the queue fills.
// Reset (synchronous, active high) sets fold_case to 1, clears the hash
// state and empties the queue and the output register.
module casefold_crc32_msb_hash #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] hash_value
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data     // fold_case
);

   cfch_pkg::item_type push_item;
   cfch_pkg::item_type head_item;
   logic push;
   logic pop;
   logic queue_full;
   logic queue_not_empty;

   cfch_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   cfch_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .not_empty (queue_not_empty),
      .full      (queue_full),
      .head_item (head_item)
   );

   cfch_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (queue_not_empty),
      .item       (head_item),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
